// ----- rtl/core/pbmc_pkg.sv -----
// pbmc_pkg: shared types, codes and helpers of the power bank mode controller
// used by pbmc_step and power_bank_mode_controller; no dependencies
package pbmc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int EVENT_W   = 3;
	localparam int MODE_W    = 2;
	localparam int LED_W     = 4;
	localparam int LEVEL_W   = 3;
	localparam int HOLD_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_THR   = 4;
	localparam int THR_IDX_W = $clog2(NUM_THR);

	localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CHG      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BOOST    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CHGBOOST = 2'd3;

	localparam logic [EVENT_W-1:0] EV_TICK    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_BUTTON  = 3'd1;
	localparam logic [EVENT_W-1:0] EV_CHG_IN  = 3'd2;
	localparam logic [EVENT_W-1:0] EV_CHG_OUT = 3'd3;
	localparam logic [EVENT_W-1:0] EV_DEV_IN  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_THR_3V0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_3V4    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_3V7    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_4V0    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_CLAMP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_LOAD    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 3'd6;

	localparam logic [SAMPLE_W-1:0] RST_THR_3V0    = 16'd29789;
	localparam logic [SAMPLE_W-1:0] RST_THR_3V4    = 16'd33761;
	localparam logic [SAMPLE_W-1:0] RST_THR_3V7    = 16'd36740;
	localparam logic [SAMPLE_W-1:0] RST_THR_4V0    = 16'd39718;
	localparam logic [SAMPLE_W-1:0] RST_RISE_CLAMP = 16'd500;
	localparam logic [SAMPLE_W-1:0] RST_NO_LOAD    = 16'd1000;
	localparam logic [HOLD_W-1:0]   RST_HOLD_TICKS = 3'd4;

	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_MID   = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH  = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 3'd5;

	localparam logic [LED_W-1:0] LEDS_OFF = 4'h0;
	localparam logic [LED_W-1:0] LEDS_ALL = 4'hF;

	typedef struct packed {
		logic [NUM_THR-1:0][SAMPLE_W-1:0] thr;
		logic [SAMPLE_W-1:0]              rise_clamp;
		logic [SAMPLE_W-1:0]              no_load_current;
		logic [HOLD_W-1:0]                led_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [EVENT_W-1:0]  event_req;
		logic [SAMPLE_W-1:0] battery_sample;
		logic [SAMPLE_W-1:0] load_current_sample;
		logic                charger_absent_pin;
		logic                charge_done_pin;
	} req_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [LED_W-1:0]   leds;
		logic [HOLD_W-1:0]  hold_count;
		logic               blink_phase;
		logic [LEVEL_W-1:0] discharge_level;
		logic               boost;
		logic               mask;
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [LED_W-1:0]   leds;
		logic               boost_enable;
		logic               switch_masked;
		logic               low_battery_alert;
		logic               unplug_indicate;
		logic [LEVEL_W-1:0] battery_level;
	} res_t;

	function automatic logic [LED_W-1:0] bar(input logic [LEVEL_W-1:0] level);
		logic [LED_W-1:0] pat;
		unique case (level)
			LEVEL_LOW:  pat = 4'h1;
			LEVEL_MID:  pat = 4'h3;
			LEVEL_HIGH: pat = 4'h7;
			LEVEL_FULL: pat = 4'hF;
			default:    pat = LEDS_OFF;
		endcase
		return pat;
	endfunction

endpackage

// ----- rtl/core/pbmc_step.sv -----
// pbmc_step: next-state and result logic for one request
// uses pbmc_pkg types, codes and the bar pattern function
module pbmc_step (
	input  pbmc_pkg::cfg_t   cfg,
	input  pbmc_pkg::req_t   req,
	input  pbmc_pkg::state_t cur,
	output pbmc_pkg::state_t nxt,
	output pbmc_pkg::res_t   res
);

	logic                            full;
	logic                            power_ok;
	logic                            unplugged;
	logic [pbmc_pkg::LEVEL_W-1:0]    level;
	logic [pbmc_pkg::LEVEL_W-1:0]    level_dn;
	logic [pbmc_pkg::LEVEL_W-1:0]    thr_off;
	logic [pbmc_pkg::SAMPLE_W-1:0]   thr_sel;
	logic [pbmc_pkg::SAMPLE_W:0]     rise_limit;
	logic [pbmc_pkg::LEVEL_W-1:0]    dl;
	logic [pbmc_pkg::LED_W-1:0]      lit;
	logic [pbmc_pkg::LED_W-1:0]      dim;
	logic [pbmc_pkg::LED_W-1:0]      disp;
	logic                            alert;
	logic                            unplug;

	assign full      = !req.charger_absent_pin && req.charge_done_pin;
	assign power_ok  = req.battery_sample >= cfg.thr[0];
	assign unplugged = req.load_current_sample < cfg.no_load_current;

	// grade against the four thresholds
	always_comb begin
		if (req.battery_sample > cfg.thr[3])
			level = pbmc_pkg::LEVEL_FULL;
		else if (req.battery_sample > cfg.thr[2])
			level = pbmc_pkg::LEVEL_HIGH;
		else if (req.battery_sample > cfg.thr[1])
			level = pbmc_pkg::LEVEL_MID;
		else if (req.battery_sample > cfg.thr[0])
			level = pbmc_pkg::LEVEL_LOW;
		else
			level = pbmc_pkg::LEVEL_EMPTY;
	end

	assign level_dn = level - pbmc_pkg::LEVEL_W'(1);

	// rising level needs its own threshold plus the clamp
	assign thr_off    = level - pbmc_pkg::LEVEL_LOW;
	assign thr_sel    = cfg.thr[thr_off[pbmc_pkg::THR_IDX_W-1:0]];
	assign rise_limit = {1'b0, thr_sel} + {1'b0, cfg.rise_clamp};
	assign dl = (level > cur.discharge_level && {1'b0, req.battery_sample} < rise_limit) ?
		level_dn : level;

	// charge blink patterns
	assign lit  = (level <= pbmc_pkg::LEVEL_LOW) ? 4'h1 : pbmc_pkg::bar(level);
	assign dim  = (level <= pbmc_pkg::LEVEL_LOW) ? pbmc_pkg::LEDS_OFF : pbmc_pkg::bar(level_dn);
	assign disp = cur.blink_phase ? dim : lit;

	always_comb begin
		nxt    = cur;
		alert  = 1'b0;
		unplug = 1'b0;
		unique case (cur.mode)
			pbmc_pkg::MODE_IDLE: begin
				unique case (req.event_req)
					pbmc_pkg::EV_TICK: begin
						if (cur.hold_count != '0) begin
							nxt.hold_count = cur.hold_count - pbmc_pkg::HOLD_W'(1);
							if (cur.hold_count == pbmc_pkg::HOLD_W'(1))
								nxt.leds = pbmc_pkg::LEDS_OFF;
						end
					end
					pbmc_pkg::EV_BUTTON: begin
						nxt.leds       = pbmc_pkg::bar(level);
						nxt.hold_count = cfg.led_hold_ticks;
					end
					pbmc_pkg::EV_CHG_IN: begin
						nxt.mode = pbmc_pkg::MODE_CHG;
						nxt.mask = 1'b1;
					end
					pbmc_pkg::EV_DEV_IN: begin
						if (power_ok) begin
							nxt.boost = 1'b1;
							nxt.mask  = 1'b1;
							nxt.mode  = pbmc_pkg::MODE_BOOST;
						end else begin
							nxt.leds = pbmc_pkg::LEDS_OFF;
							alert    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			pbmc_pkg::MODE_CHG: begin
				unique case (req.event_req)
					pbmc_pkg::EV_TICK: begin
						if (full) begin
							nxt.leds = pbmc_pkg::LEDS_ALL;
						end else begin
							nxt.leds        = disp;
							nxt.blink_phase = !cur.blink_phase;
							if (req.charger_absent_pin) begin
								nxt.mode = pbmc_pkg::MODE_IDLE;
								nxt.mask = 1'b0;
								nxt.leds = pbmc_pkg::LEDS_OFF;
							end
						end
					end
					pbmc_pkg::EV_CHG_OUT: begin
						nxt.mode = pbmc_pkg::MODE_IDLE;
						nxt.mask = 1'b0;
						nxt.leds = pbmc_pkg::LEDS_OFF;
					end
					pbmc_pkg::EV_DEV_IN: begin
						if (power_ok) begin
							nxt.boost = 1'b1;
							nxt.mode  = pbmc_pkg::MODE_CHGBOOST;
						end else begin
							nxt.leds = pbmc_pkg::LEDS_OFF;
							alert    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			pbmc_pkg::MODE_BOOST: begin
				unique case (req.event_req)
					pbmc_pkg::EV_TICK: begin
						if (unplugged) begin
							nxt.boost = 1'b0;
							nxt.mode  = pbmc_pkg::MODE_IDLE;
							nxt.mask  = 1'b0;
							nxt.leds  = pbmc_pkg::LEDS_OFF;
							unplug    = 1'b1;
						end else begin
							nxt.discharge_level = dl;
							if (dl == pbmc_pkg::LEVEL_EMPTY) begin
								nxt.leds  = pbmc_pkg::LEDS_OFF;
								alert     = 1'b1;
								nxt.boost = 1'b0;
								nxt.mode  = pbmc_pkg::MODE_IDLE;
								nxt.mask  = 1'b0;
							end else begin
								nxt.leds = pbmc_pkg::bar(dl);
							end
						end
					end
					pbmc_pkg::EV_CHG_IN: nxt.mode = pbmc_pkg::MODE_CHGBOOST;
					default: ;
				endcase
			end
			pbmc_pkg::MODE_CHGBOOST: begin
				unique case (req.event_req)
					pbmc_pkg::EV_TICK: begin
						if (full) begin
							nxt.mode = pbmc_pkg::MODE_IDLE;
							nxt.mask = 1'b0;
						end else if (unplugged) begin
							nxt.boost = 1'b0;
							nxt.mode  = pbmc_pkg::MODE_CHG;
							nxt.mask  = 1'b0;
							nxt.leds  = pbmc_pkg::LEDS_OFF;
							unplug    = 1'b1;
						end else begin
							nxt.leds        = disp;
							nxt.blink_phase = !cur.blink_phase;
						end
					end
					pbmc_pkg::EV_CHG_OUT: nxt.mode = pbmc_pkg::MODE_BOOST;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		res.mode              = nxt.mode;
		res.leds              = nxt.leds;
		res.boost_enable      = nxt.boost;
		res.switch_masked     = nxt.mask;
		res.low_battery_alert = alert;
		res.unplug_indicate   = unplug;
		res.battery_level     = level;
	end

endmodule

// ----- rtl/core/power_bank_mode_controller.sv -----
// power_bank_mode_controller: top level with configuration, request register,
// controller state and result register; uses pbmc_pkg and pbmc_step
//
// Every accepted request gives exactly one result. A request is captured in an
// input register, one pass of pbmc_step computes the next mode, LED bar and
// flags from it, and the result register holds the answer until it is taken.
// Throughput is one request per cycle while results are taken; the only loop is
// the controller state, which is updated in the same cycle that a result is
// loaded. The input side keeps accepting while a result waits, until both
// registers are full.
module power_bank_mode_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pbmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbmc_pkg::SAMPLE_W-1:0]     cfg_wdata,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [pbmc_pkg::EVENT_W-1:0]      event_req,
	input  logic [pbmc_pkg::SAMPLE_W-1:0]     battery_sample,
	input  logic [pbmc_pkg::SAMPLE_W-1:0]     load_current_sample,
	input  logic                              charger_absent_pin,
	input  logic                              charge_done_pin,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [pbmc_pkg::MODE_W-1:0]       mode,
	output logic [pbmc_pkg::LED_W-1:0]        leds,
	output logic                              boost_enable,
	output logic                              switch_masked,
	output logic                              low_battery_alert,
	output logic                              unplug_indicate,
	output logic [pbmc_pkg::LEVEL_W-1:0]      battery_level
);

	pbmc_pkg::cfg_t   cfg_q;
	pbmc_pkg::req_t   req_s1;
	logic             valid_s1;
	pbmc_pkg::state_t state_q;
	pbmc_pkg::state_t state_nxt;
	pbmc_pkg::res_t   res_nxt;
	pbmc_pkg::res_t   res_q;
	logic             res_valid_q;
	logic             advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr[0]          <= pbmc_pkg::RST_THR_3V0;
			cfg_q.thr[1]          <= pbmc_pkg::RST_THR_3V4;
			cfg_q.thr[2]          <= pbmc_pkg::RST_THR_3V7;
			cfg_q.thr[3]          <= pbmc_pkg::RST_THR_4V0;
			cfg_q.rise_clamp      <= pbmc_pkg::RST_RISE_CLAMP;
			cfg_q.no_load_current <= pbmc_pkg::RST_NO_LOAD;
			cfg_q.led_hold_ticks  <= pbmc_pkg::RST_HOLD_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbmc_pkg::CFG_THR_3V0:    cfg_q.thr[0] <= cfg_wdata;
				pbmc_pkg::CFG_THR_3V4:    cfg_q.thr[1] <= cfg_wdata;
				pbmc_pkg::CFG_THR_3V7:    cfg_q.thr[2] <= cfg_wdata;
				pbmc_pkg::CFG_THR_4V0:    cfg_q.thr[3] <= cfg_wdata;
				pbmc_pkg::CFG_RISE_CLAMP: cfg_q.rise_clamp <= cfg_wdata;
				pbmc_pkg::CFG_NO_LOAD:    cfg_q.no_load_current <= cfg_wdata;
				pbmc_pkg::CFG_HOLD_TICKS:
					cfg_q.led_hold_ticks <= cfg_wdata[pbmc_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance   = !res_valid_q || res_ready;
	assign req_ready = !valid_s1 || advance;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_ready)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1.event_req           <= event_req;
			req_s1.battery_sample      <= battery_sample;
			req_s1.load_current_sample <= load_current_sample;
			req_s1.charger_absent_pin  <= charger_absent_pin;
			req_s1.charge_done_pin     <= charge_done_pin;
		end
	end

	pbmc_step u_step (
		.cfg (cfg_q),
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode            <= pbmc_pkg::MODE_IDLE;
			state_q.leds            <= pbmc_pkg::LEDS_OFF;
			state_q.hold_count      <= '0;
			state_q.blink_phase     <= 1'b0;
			state_q.discharge_level <= pbmc_pkg::LEVEL_FULL;
			state_q.boost           <= 1'b0;
			state_q.mask            <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			res_q <= res_nxt;
	end

	assign res_valid         = res_valid_q;
	assign mode              = res_q.mode;
	assign leds              = res_q.leds;
	assign boost_enable      = res_q.boost_enable;
	assign switch_masked     = res_q.switch_masked;
	assign low_battery_alert = res_q.low_battery_alert;
	assign unplug_indicate   = res_q.unplug_indicate;
	assign battery_level     = res_q.battery_level;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && res_valid_q && !res_ready))
		else $error("request side stalled with a free register");

	a_alert_blanks_bar: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.low_battery_alert) |-> (res_q.leds == pbmc_pkg::LEDS_OFF))
		else $error("low battery alert with lit bar");

	a_unplug_stops_boost: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.unplug_indicate) |->
			(!res_q.boost_enable && res_q.leds == pbmc_pkg::LEDS_OFF))
		else $error("unplug pulse with boost still on");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.low_battery_alert && res_q.unplug_indicate))
		else $error("alert and unplug pulses together");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.battery_level >= pbmc_pkg::LEVEL_EMPTY &&
			res_q.battery_level <= pbmc_pkg::LEVEL_FULL))
		else $error("battery level out of range");

	a_state_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> $stable(state_q))
		else $error("controller state moved while result stalled");

endmodule

// ----- tb/sv/tb_power_bank_mode_controller.sv -----
// tb_power_bank_mode_controller: self-checking testbench of the power bank mode controller
// directed and random requests against an in-bench status predictor; uses pbmc_pkg and the
// power_bank_mode_controller rtl
module tb_power_bank_mode_controller;
	import pbmc_pkg::*;

	localparam logic [EVENT_W-1:0]   EV_SPARE_FIRST = 3'd5;
	localparam logic [EVENT_W-1:0]   EV_SPARE_LAST  = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 3'd7;
	localparam int MAX_WAIT      = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 1000;
	localparam int REPORT_CAP    = 200;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SAMPLE_W-1:0]  cfg_wdata;
	logic                 req_valid;
	logic                 req_ready;
	logic [EVENT_W-1:0]   event_req;
	logic [SAMPLE_W-1:0]  battery_sample;
	logic [SAMPLE_W-1:0]  load_current_sample;
	logic                 charger_absent_pin;
	logic                 charge_done_pin;
	logic                 res_valid;
	logic                 res_ready;
	logic [MODE_W-1:0]    mode;
	logic [LED_W-1:0]     leds;
	logic                 boost_enable;
	logic                 switch_masked;
	logic                 low_battery_alert;
	logic                 unplug_indicate;
	logic [LEVEL_W-1:0]   battery_level;

	logic [SAMPLE_W-1:0] thr_model [NUM_THR] = '{RST_THR_3V0, RST_THR_3V4, RST_THR_3V7,
		RST_THR_4V0};
	logic [SAMPLE_W-1:0] clamp_model      = RST_RISE_CLAMP;
	logic [SAMPLE_W-1:0] no_load_model    = RST_NO_LOAD;
	logic [HOLD_W-1:0]   hold_ticks_model = RST_HOLD_TICKS;

	logic [MODE_W-1:0]  st_mode  = MODE_IDLE;
	logic [LED_W-1:0]   st_leds  = LEDS_OFF;
	logic [HOLD_W-1:0]  st_hold  = '0;
	logic               st_phase = 1'b0;
	logic [LEVEL_W-1:0] st_last  = LEVEL_FULL;
	logic               st_boost = 1'b0;
	logic               st_mask  = 1'b0;

	res_t expected_status [$];
	int   errors       = 0;
	int   quiet_cycles = 0;
	bit   no_gaps      = 1'b0;

	power_bank_mode_controller uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.req_valid           (req_valid),
		.req_ready           (req_ready),
		.event_req           (event_req),
		.battery_sample      (battery_sample),
		.load_current_sample (load_current_sample),
		.charger_absent_pin  (charger_absent_pin),
		.charge_done_pin     (charge_done_pin),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.mode                (mode),
		.leds                (leds),
		.boost_enable        (boost_enable),
		.switch_masked       (switch_masked),
		.low_battery_alert   (low_battery_alert),
		.unplug_indicate     (unplug_indicate),
		.battery_level       (battery_level)
	);

	always #2 clk = ~clk;

	function automatic logic [LED_W-1:0] bar_pattern(input logic [LEVEL_W-1:0] level);
		case (level)
			LEVEL_LOW:  return 4'h1;
			LEVEL_MID:  return 4'h3;
			LEVEL_HIGH: return 4'h7;
			LEVEL_FULL: return 4'hF;
			default:    return LEDS_OFF;
		endcase
	endfunction

	function automatic logic [LEVEL_W-1:0] grade_level(input logic [SAMPLE_W-1:0] batt);
		if (batt > thr_model[3]) return LEVEL_FULL;
		if (batt > thr_model[2]) return LEVEL_HIGH;
		if (batt > thr_model[1]) return LEVEL_MID;
		if (batt > thr_model[0]) return LEVEL_LOW;
		return LEVEL_EMPTY;
	endfunction

	task automatic show_charge(input logic [LEVEL_W-1:0] level);
		logic [LED_W-1:0] lit;
		logic [LED_W-1:0] dim;
		if (level <= LEVEL_LOW) begin
			lit = bar_pattern(LEVEL_LOW);
			dim = LEDS_OFF;
		end else begin
			lit = bar_pattern(level);
			dim = bar_pattern(level - LEVEL_W'(1));
		end
		st_leds = st_phase ? dim : lit;
		st_phase = ~st_phase;
	endtask

	task automatic compute_status(input req_t r, output res_t o);
		logic               full;
		logic               power_ok;
		logic               unplugged;
		logic               alert;
		logic               unplug;
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] dl;
		logic [SAMPLE_W:0]  rise_limit;
		full = !r.charger_absent_pin && r.charge_done_pin;
		power_ok = r.battery_sample >= thr_model[0];
		unplugged = r.load_current_sample < no_load_model;
		level = grade_level(r.battery_sample);
		alert = 1'b0;
		unplug = 1'b0;
		case (st_mode)
			MODE_IDLE: begin
				if (r.event_req == EV_TICK) begin
					if (st_hold != 0) begin
						st_hold = st_hold - HOLD_W'(1);
						if (st_hold == 0) st_leds = LEDS_OFF;
					end
				end else if (r.event_req == EV_BUTTON) begin
					st_leds = bar_pattern(level);
					st_hold = hold_ticks_model;
				end else if (r.event_req == EV_CHG_IN) begin
					st_mode = MODE_CHG;
					st_mask = 1'b1;
				end else if (r.event_req == EV_DEV_IN) begin
					if (power_ok) begin
						st_boost = 1'b1;
						st_mask = 1'b1;
						st_mode = MODE_BOOST;
					end else begin
						st_leds = LEDS_OFF;
						alert = 1'b1;
					end
				end
			end
			MODE_CHG: begin
				if (r.event_req == EV_TICK) begin
					if (full) begin
						st_leds = LEDS_ALL;
					end else begin
						show_charge(level);
						if (r.charger_absent_pin) begin
							st_mode = MODE_IDLE;
							st_mask = 1'b0;
							st_leds = LEDS_OFF;
						end
					end
				end else if (r.event_req == EV_CHG_OUT) begin
					st_mode = MODE_IDLE;
					st_mask = 1'b0;
					st_leds = LEDS_OFF;
				end else if (r.event_req == EV_DEV_IN) begin
					if (power_ok) begin
						st_boost = 1'b1;
						st_mode = MODE_CHGBOOST;
					end else begin
						st_leds = LEDS_OFF;
						alert = 1'b1;
					end
				end
			end
			MODE_BOOST: begin
				if (r.event_req == EV_TICK) begin
					if (unplugged) begin
						st_boost = 1'b0;
						st_mode = MODE_IDLE;
						st_mask = 1'b0;
						st_leds = LEDS_OFF;
						unplug = 1'b1;
					end else begin
						dl = level;
						// a rising grade needs the clamp margin over its own threshold
						if (dl > st_last) begin
							rise_limit = {1'b0, thr_model[THR_IDX_W'(dl - LEVEL_LOW)]}
								+ {1'b0, clamp_model};
							if ({1'b0, r.battery_sample} < rise_limit) dl = dl - LEVEL_W'(1);
						end
						st_last = dl;
						if (dl == LEVEL_EMPTY) begin
							st_leds = LEDS_OFF;
							alert = 1'b1;
							st_boost = 1'b0;
							st_mode = MODE_IDLE;
							st_mask = 1'b0;
						end else begin
							st_leds = bar_pattern(dl);
						end
					end
				end else if (r.event_req == EV_CHG_IN) begin
					st_mode = MODE_CHGBOOST;
				end
			end
			default: begin
				if (r.event_req == EV_TICK) begin
					if (full) begin
						st_mode = MODE_IDLE;
						st_mask = 1'b0;
					end else if (unplugged) begin
						st_boost = 1'b0;
						st_mode = MODE_CHG;
						st_mask = 1'b0;
						st_leds = LEDS_OFF;
						unplug = 1'b1;
					end else begin
						show_charge(level);
					end
				end else if (r.event_req == EV_CHG_OUT) begin
					st_mode = MODE_BOOST;
				end
			end
		endcase
		o.mode = st_mode;
		o.leds = st_leds;
		o.boost_enable = st_boost;
		o.switch_masked = st_mask;
		o.low_battery_alert = alert;
		o.unplug_indicate = unplug;
		o.battery_level = level;
	endtask

	task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
		input logic [SAMPLE_W-1:0] want);
		errors++;
		if (errors <= REPORT_CAP)
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
	endtask

	task automatic send_event(input logic [EVENT_W-1:0] ev, input logic [SAMPLE_W-1:0] batt,
		input logic [SAMPLE_W-1:0] load, input logic absent, input logic done);
		req_t r;
		res_t want;
		int   gap;
		r.event_req = ev;
		r.battery_sample = batt;
		r.load_current_sample = load;
		r.charger_absent_pin = absent;
		r.charge_done_pin = done;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		event_req <= ev;
		battery_sample <= batt;
		load_current_sample <= load;
		charger_absent_pin <= absent;
		charge_done_pin <= done;
		do @(posedge clk); while (req_ready !== 1'b1);
		compute_status(r, want);
		expected_status.push_back(want);
	endtask

	task automatic finish_phase();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_THR_3V0:    thr_model[0] = data;
			CFG_THR_3V4:    thr_model[1] = data;
			CFG_THR_3V7:    thr_model[2] = data;
			CFG_THR_4V0:    thr_model[3] = data;
			CFG_RISE_CLAMP: clamp_model = data;
			CFG_NO_LOAD:    no_load_model = data;
			CFG_HOLD_TICKS: hold_ticks_model = data[HOLD_W-1:0];
			default: ;
		endcase
	endtask

	function automatic bit event_matters(input logic [EVENT_W-1:0] ev);
		case (st_mode)
			MODE_IDLE:  return ev != EV_CHG_OUT;
			MODE_CHG:   return ev == EV_TICK || ev == EV_CHG_OUT || ev == EV_DEV_IN;
			MODE_BOOST: return ev == EV_TICK || ev == EV_CHG_IN;
			default:    return ev == EV_TICK || ev == EV_CHG_OUT;
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_battery(input bit want_power);
		int val;
		case ($urandom_range(0, 3))
			0: val = int'($urandom_range(0, 16'hFFFF));
			1: val = int'(thr_model[$urandom_range(0, NUM_THR - 1)])
				+ int'($urandom_range(0, 8)) - 4;
			2: val = int'(thr_model[$urandom_range(0, NUM_THR - 1)]) + int'(clamp_model)
				+ int'($urandom_range(0, 8)) - 4;
			default: val = $urandom_range(0, 1) ? 16'hFFFF : 0;
		endcase
		if (val < 0) val = 0;
		if (val > 16'hFFFF) val = 16'hFFFF;
		if (want_power && val < int'(thr_model[0]) && $urandom_range(0, 9) != 0)
			val = int'($urandom_range(thr_model[0], 16'hFFFF));
		return val[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_load();
		int pick;
		pick = $urandom_range(0, 99);
		if (no_load_model == 0 || pick < 65)
			return SAMPLE_W'($urandom_range(no_load_model, 16'hFFFF));
		if (pick < 75) return no_load_model - SAMPLE_W'(1);
		if (pick < 80) return no_load_model;
		return SAMPLE_W'($urandom_range(0, no_load_model - 1));
	endfunction

	task automatic random_events(input int count);
		logic [EVENT_W-1:0]  ev;
		logic [SAMPLE_W-1:0] batt;
		logic                absent;
		logic                done;
		int                  pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) ev = EV_TICK;
			else if (pick < 55) ev = EV_BUTTON;
			else if (pick < 67) ev = EV_CHG_IN;
			else if (pick < 79) ev = EV_CHG_OUT;
			else if (pick < 95) ev = EV_DEV_IN;
			else ev = EVENT_W'($urandom_range(EV_SPARE_FIRST, EV_SPARE_LAST));
			// mostly steer away from events the current mode ignores
			if (ev <= EV_DEV_IN && !event_matters(ev) && $urandom_range(0, 3) != 0) ev = EV_TICK;
			batt = pick_battery(ev == EV_DEV_IN);
			if (st_mode == MODE_IDLE) absent = $urandom_range(0, 1) != 0;
			else absent = $urandom_range(0, 99) < 15;
			done = $urandom_range(0, 3) == 0;
			send_event(ev, batt, pick_load(), absent, done);
		end
	endtask

	task automatic randomize_config();
		logic [SAMPLE_W-1:0] t [NUM_THR];
		logic [SAMPLE_W-1:0] tmp;
		bit                  sorted;
		sorted = $urandom_range(0, 4) != 0;
		foreach (t[i]) t[i] = SAMPLE_W'($urandom_range(0, 16'hFFFF));
		if (sorted) begin
			for (int i = 1; i < NUM_THR; i++)
				for (int j = i; j > 0 && t[j-1] > t[j]; j--) begin
					tmp = t[j];
					t[j] = t[j-1];
					t[j-1] = tmp;
				end
		end
		write_reg(CFG_THR_3V0, t[0]);
		write_reg(CFG_THR_3V4, t[1]);
		write_reg(CFG_THR_3V7, t[2]);
		write_reg(CFG_THR_4V0, t[3]);
		write_reg(CFG_RISE_CLAMP, SAMPLE_W'($urandom_range(0, 99) < 85 ?
			$urandom_range(0, 2000) : $urandom_range(0, 16'hFFFF)));
		write_reg(CFG_NO_LOAD, SAMPLE_W'($urandom_range(0, 4000)));
		write_reg(CFG_HOLD_TICKS, SAMPLE_W'($urandom_range(1, 7)));
	endtask

	// button display and hold countdown, a spare event code
	task automatic test_idle_display();
		send_event(EV_BUTTON, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_BUTTON, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
		repeat (4) send_event(EV_TICK, 16'h1234, 16'h0000, 1'b1, 1'b1);
		send_event(EV_SPARE_LAST, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		finish_phase();
	endtask

	// device plug with low and usable battery, then unplug
	task automatic test_idle_device();
		send_event(EV_DEV_IN, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_DEV_IN, RST_THR_3V0, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_TICK, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
		finish_phase();
	endtask

	// blinking bar, full battery, alert while charging, charger removal
	task automatic test_charging();
		send_event(EV_CHG_IN, 16'd37000, 16'd5000, 1'b0, 1'b0);
		send_event(EV_TICK, 16'd37000, 16'd5000, 1'b0, 1'b0);
		send_event(EV_TICK, 16'd37000, 16'd5000, 1'b0, 1'b0);
		send_event(EV_TICK, 16'd30000, 16'd5000, 1'b0, 1'b1);
		send_event(EV_DEV_IN, 16'h0000, 16'd5000, 1'b0, 1'b0);
		send_event(EV_CHG_OUT, 16'd30000, 16'd5000, 1'b1, 1'b1);
		finish_phase();
	endtask

	// discharge level steps, clamped rise, empty battery
	task automatic test_boost_discharge();
		send_event(EV_DEV_IN, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_TICK, RST_THR_4V0 + 1'b1, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_TICK, 16'd30000, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_TICK, RST_THR_3V7 + 1'b1, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
		finish_phase();
	endtask

	// charge plus boost entry and exit, full battery while boosting
	task automatic test_charge_and_boost();
		send_event(EV_CHG_IN, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_event(EV_DEV_IN, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_event(EV_TICK, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_event(EV_CHG_OUT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		send_event(EV_CHG_IN, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_event(EV_TICK, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		finish_phase();
	endtask

	task automatic test_extreme_settings();
		write_reg(CFG_THR_3V0, '0);
		write_reg(CFG_THR_3V4, '0);
		write_reg(CFG_THR_3V7, '0);
		write_reg(CFG_THR_4V0, '0);
		write_reg(CFG_RISE_CLAMP, '0);
		write_reg(CFG_NO_LOAD, '0);
		write_reg(CFG_HOLD_TICKS, 16'd7);
		random_events(60);
		finish_phase();
		no_gaps = 1'b1;
		write_reg(CFG_THR_3V0, 16'hFFFF);
		write_reg(CFG_THR_3V4, 16'hFFFF);
		write_reg(CFG_THR_3V7, 16'hFFFF);
		write_reg(CFG_THR_4V0, 16'hFFFF);
		write_reg(CFG_RISE_CLAMP, 16'hFFFF);
		write_reg(CFG_NO_LOAD, 16'hFFFF);
		write_reg(CFG_HOLD_TICKS, '0);
		write_reg(CFG_SPARE, SAMPLE_W'($urandom_range(0, 16'hFFFF)));
		random_events(60);
		finish_phase();
		no_gaps = 1'b0;
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 6; phase++) begin
			no_gaps = (phase % 3) == 2;
			randomize_config();
			random_events(105);
			finish_phase();
		end
		no_gaps = 1'b0;
	endtask

	initial begin : result_checker
		res_t want;
		int   stall;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
			repeat (stall) begin
				@(negedge clk);
				res_ready <= 1'b0;
			end
			@(negedge clk);
			res_ready <= 1'b1;
			do @(posedge clk); while (res_valid !== 1'b1);
			if (expected_status.size() == 0) begin
				report_mismatch("result with no pending request", '0, '0);
			end else begin
				want = expected_status.pop_front();
				if (mode !== want.mode)
					report_mismatch("mode", SAMPLE_W'(mode), SAMPLE_W'(want.mode));
				if (leds !== want.leds)
					report_mismatch("leds", SAMPLE_W'(leds), SAMPLE_W'(want.leds));
				if (boost_enable !== want.boost_enable)
					report_mismatch("boost_enable", SAMPLE_W'(boost_enable),
						SAMPLE_W'(want.boost_enable));
				if (switch_masked !== want.switch_masked)
					report_mismatch("switch_masked", SAMPLE_W'(switch_masked),
						SAMPLE_W'(want.switch_masked));
				if (low_battery_alert !== want.low_battery_alert)
					report_mismatch("low_battery_alert", SAMPLE_W'(low_battery_alert),
						SAMPLE_W'(want.low_battery_alert));
				if (unplug_indicate !== want.unplug_indicate)
					report_mismatch("unplug_indicate", SAMPLE_W'(unplug_indicate),
						SAMPLE_W'(want.unplug_indicate));
				if (battery_level !== want.battery_level)
					report_mismatch("battery_level", SAMPLE_W'(battery_level),
						SAMPLE_W'(want.battery_level));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_THR_3V0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		event_req = EV_TICK;
		battery_sample = '0;
		load_current_sample = '0;
		charger_absent_pin = 1'b1;
		charge_done_pin = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_display();
		test_idle_device();
		test_charging();
		test_boost_discharge();
		test_charge_and_boost();
		test_extreme_settings();
		test_random_settings();
		finish_phase();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
